// ===== design/ordered_value_list_table_unit_macros.svh =====
// Assertion macros shared by the ordered value list modules
`ifndef ORDERED_VALUE_LIST_TABLE_UNIT_MACROS_SVH
`define ORDERED_VALUE_LIST_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define OVLT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset
`define OVLT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ovlt_pkg.sv =====
// Shared types, command codes and defaults for the ordered value list
package ovlt_pkg;

  // Default store depth
  localparam int DEPTH_DEF = 64;

  // Command codes
  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_COUNT  = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  // Result status codes
  localparam logic STAT_OK   = 1'b0;
  localparam logic STAT_FULL = 1'b1;

  // Counts on the result word are reported on 7 bits
  typedef logic [6:0] cnt_out_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] item_value;
  } in_word_t;

  typedef struct packed {
    logic     status;
    cnt_out_t match_count;
    cnt_out_t list_size;
  } out_word_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_RESULT
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // latch input word, clear scan counters
    logic append;    // append latched value if room
    logic issue;     // read the entry at the scan pointer
    logic commit;    // scan done, update size after remove
    logic out_load;  // move result into the output register
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_append;
    logic is_scan;
    logic scan_more;
    logic cmp_vld;
  } dp_stat_t;

endpackage

// ===== design/ovlt_datapath.sv =====
// Datapath: entry memory, scan pointers, compare and result register
`include "ordered_value_list_table_unit_macros.svh"

module ovlt_datapath #(
  parameter int DEPTH = ovlt_pkg::DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ovlt_pkg::in_word_t  in_word,
  input  ovlt_pkg::ctl_cmd_t  cmd,
  output ovlt_pkg::dp_stat_t  stat,
  output ovlt_pkg::out_word_t out_word
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [31:0]         mem [DEPTH];
  logic [31:0]         rdata_r;
  ovlt_pkg::in_word_t  req_r;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       rd_r, rd_nxt;
  logic [CW-1:0]       wr_r, wr_nxt;
  logic [CW-1:0]       match_r, match_nxt;
  logic                status_r, status_nxt;
  logic                cmp_vld_r;
  ovlt_pkg::out_word_t out_r;

  logic          full;
  logic          hit;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;

  assign full = (count_r == CW'(DEPTH));
  assign hit  = (rdata_r == req_r.item_value);

  // Status toward the controller
  assign stat.is_append = (req_r.cmd == ovlt_pkg::CMD_APPEND);
  assign stat.is_scan   = (req_r.cmd == ovlt_pkg::CMD_COUNT) ||
                          (req_r.cmd == ovlt_pkg::CMD_REMOVE);
  assign stat.scan_more = (rd_r < count_r);
  assign stat.cmp_vld   = cmp_vld_r;

  // Single write port: append at the tail, or compaction during remove
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count_r[AW-1:0];
    mem_wdata = req_r.item_value;
    if (cmd.append && !full) begin
      mem_we = 1'b1;
    end else if (cmp_vld_r && !hit && req_r.cmd == ovlt_pkg::CMD_REMOVE) begin
      mem_we    = 1'b1;
      mem_waddr = wr_r[AW-1:0];
      mem_wdata = rdata_r;
    end
  end

  // Entry memory with registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.issue) begin
      rdata_r <= mem[rd_r[AW-1:0]];
    end
  end

  // Scan counters, size and status
  always_comb begin
    count_nxt  = count_r;
    rd_nxt     = rd_r;
    wr_nxt     = wr_r;
    match_nxt  = match_r;
    status_nxt = status_r;
    if (cmd.load) begin
      rd_nxt     = '0;
      wr_nxt     = '0;
      match_nxt  = '0;
      status_nxt = ovlt_pkg::STAT_OK;
    end
    if (cmd.append) begin
      if (full) begin
        status_nxt = ovlt_pkg::STAT_FULL;
      end else begin
        count_nxt = count_r + CW'(1);
      end
    end
    if (cmd.issue) begin
      rd_nxt = rd_r + CW'(1);
    end
    if (cmp_vld_r) begin
      if (hit) begin
        match_nxt = match_r + CW'(1);
      end else begin
        wr_nxt = wr_r + CW'(1);
      end
    end
    if (cmd.commit && req_r.cmd == ovlt_pkg::CMD_REMOVE) begin
      count_nxt = wr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      cmp_vld_r <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    rd_r     <= rd_nxt;
    wr_r     <= wr_nxt;
    match_r  <= match_nxt;
    status_r <= status_nxt;
    if (cmd.load) begin
      req_r <= in_word;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.status      <= status_r;
      out_r.match_count <= ovlt_pkg::cnt_out_t'(match_r);
      out_r.list_size   <= ovlt_pkg::cnt_out_t'(count_r);
    end
  end

  assign out_word = out_r;

  `OVLT_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(DEPTH), "entry count above depth")
  `OVLT_ASSERT_NOW(a_remove_tally, cmd.commit,
    ({1'b0, wr_r} + {1'b0, match_r}) == {1'b0, rd_r}, "scan tally does not add up")
  `OVLT_ASSERT_NEXT(a_full_refuse, cmd.append && full,
    (count_r == CW'(DEPTH)) && (status_r == ovlt_pkg::STAT_FULL), "full append not refused")

endmodule

// ===== design/ovlt_ctrl.sv =====
// Controller: command sequencing and output handshake
`include "ordered_value_list_table_unit_macros.svh"

module ovlt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  ovlt_pkg::dp_stat_t stat,
  output ovlt_pkg::ctl_cmd_t cmd
);

  ovlt_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ovlt_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ovlt_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ovlt_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ovlt_pkg::ST_EXEC;
        end
      end
      ovlt_pkg::ST_EXEC: begin
        if (stat.is_append) begin
          cmd.append = 1'b1;
          state_nxt  = ovlt_pkg::ST_RESULT;
        end else if (stat.is_scan) begin
          state_nxt = ovlt_pkg::ST_SCAN;
        end else begin
          state_nxt = ovlt_pkg::ST_RESULT;
        end
      end
      ovlt_pkg::ST_SCAN: begin
        // one read a cycle; finish once the last compare has retired
        cmd.issue = stat.scan_more;
        if (!stat.scan_more && !stat.cmp_vld) begin
          cmd.commit = 1'b1;
          state_nxt  = ovlt_pkg::ST_RESULT;
        end
      end
      ovlt_pkg::ST_RESULT: begin
        if (slot_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ovlt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ovlt_pkg::ST_IDLE;
      end
    endcase
  end

  `OVLT_ASSERT_NOW(a_no_overwrite, cmd.out_load, slot_free, "result overwritten before taken")
  `OVLT_ASSERT_NEXT(a_accept_exec, in_valid && in_ready, state_r == ovlt_pkg::ST_EXEC,
    "accepted word not executed")
  `OVLT_ASSERT_NEXT(a_out_hold, out_valid_r && !out_ready, out_valid_r,
    "result dropped before taken")

endmodule

// ===== design/ordered_value_list_table_unit.sv =====
// Ordered value list: append, count matches and remove all matches in a fixed store.
// One word is taken at a time. Append and the unused code pass from acceptance through
// the execute and result states to the result register; count and remove walk the stored
// entries through the memory's read port one entry per cycle. A new word is accepted once
// the current result is in the output register, while that result still waits to be taken.
// No clearing pass after reset: the size starts at zero.
module ordered_value_list_table_unit #(
  parameter int DEPTH = ovlt_pkg::DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ovlt_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output ovlt_pkg::out_word_t out_word
);

  ovlt_pkg::ctl_cmd_t cmd;
  ovlt_pkg::dp_stat_t stat;

  ovlt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ovlt_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .cmd      (cmd),
    .stat     (stat),
    .out_word (out_word)
  );

endmodule
